### hdl/pfp_pkg.sv
package pfp_pkg;

    // Frame layout
    localparam logic [7:0] START_A      = 8'h42;
    localparam logic [7:0] START_B      = 8'h4D;
    localparam logic [4:0] POS_START_A  = 5'd0;
    localparam logic [4:0] POS_START_B  = 5'd1;
    localparam logic [4:0] POS_LENGTH   = 5'd3;
    localparam logic [4:0] POS_PM_HI    = 5'd6;
    localparam logic [4:0] POS_PM_LO    = 5'd7;
    localparam logic [4:0] POS_VERSION  = 5'd28;
    localparam logic [4:0] POS_ERROR    = 5'd29;
    localparam logic [4:0] POS_CKS_HI   = 5'd30;
    localparam logic [4:0] POS_LAST     = 5'd31;
    localparam logic [4:0] WORD_BASE    = 5'd4;

    // Word correction
    localparam logic [15:0] LIN_LIMIT   = 16'd500;
    localparam logic [15:0] SQ_LIMIT    = 16'd600;
    localparam logic [24:0] GAIN_NUM    = 25'd6;
    localparam logic [24:0] DIV_SQ      = 25'd500;
    localparam logic [24:0] DIV_LIN     = 25'd5;
    localparam int unsigned RECIP_SHIFT = 27;
    localparam logic [24:0] RECIP_SQ    = 25'((64'd1 << RECIP_SHIFT) / 64'd500);
    localparam logic [24:0] RECIP_LIN   = 25'((64'd1 << RECIP_SHIFT) / 64'd5);

    // Shared multiplier operand widths
    localparam int unsigned MUL_A_W     = 19;
    localparam int unsigned MUL_B_W     = 25;
    localparam int unsigned MUL_Y_W     = MUL_A_W + MUL_B_W;
    localparam int unsigned QUOT_W      = 17;
    localparam int unsigned REM_W       = 10;

    // Configuration registers
    localparam logic REG_THRESHOLD      = 1'b0;
    localparam logic REG_LENGTH         = 1'b1;
    localparam logic [15:0] THRESHOLD_RESET = 16'd115;
    localparam logic [7:0]  LENGTH_RESET    = 8'd28;

    localparam int unsigned DATA_WORDS_DEF = 12;

endpackage

### hdl/particle_sensor_frame_parser_top.sv
// Flow: a byte that does not end a frame is taken while the sequencer idles; a frame's
// last byte also waits for any unaccepted result. A bad checksum's single result passes
// through the LOAD_OUT state and then the output register before it shows on m_tvalid.
// A good frame walks its words through one shared multiplier; each word takes at most two
// frame-memory reads, three multiplies, a correction and the output load, which may stall.
// Reset (aresetn low, synchronous) clears the position, held values and control; registers reload.
module particle_sensor_frame_parser_top #(
    parameter int unsigned DATA_WORDS = pfp_pkg::DATA_WORDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Input requests: one received serial byte each.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte

    // Result requests.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // [3:0] word_index, [19:4] word_value, [35:20] pm25_level,
                                    // [43:36] version_byte, [51:44] error_byte, [55:52] zero
    output logic [1:0]  m_tuser,    // [0] sum_ok, [1] overload
    output logic        m_tlast,    // last

    // Configuration write port.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    // Sequencer states. Each corrected word goes RD_HI, RD_LO, CLASSIFY and, when the
    // value needs scaling, MUL_RECIP, MUL_REM and FIX before it is loaded in LOAD_OUT.
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_RD_HI     = 3'd1;
    localparam logic [2:0] S_RD_LO     = 3'd2;
    localparam logic [2:0] S_CLASSIFY  = 3'd3;
    localparam logic [2:0] S_MUL_RECIP = 3'd4;
    localparam logic [2:0] S_MUL_REM   = 3'd5;
    localparam logic [2:0] S_FIX       = 3'd6;
    localparam logic [2:0] S_LOAD_OUT  = 3'd7;

    logic [2:0]  state_reg, state_next;

    // Configuration registers.
    logic [15:0] threshold_reg;
    logic [7:0]  length_reg;

    // Frame tracking done as bytes stream in: the running checksum and the few
    // bytes that feed the held values are captured on the fly.
    logic [4:0]  pos_reg;
    logic [15:0] sum_reg;
    logic [7:0]  pm_hi_reg, pm_lo_reg, version_reg, error_reg, cks_hi_reg;

    logic [15:0] held_pm25_reg;
    logic [7:0]  held_version_reg;
    logic [7:0]  held_error_reg;

    // The frame itself lives in a small memory; the word walk reads it back one byte a cycle.
    logic [7:0]  frame_mem [32];
    logic [4:0]  rd_addr;
    logic [7:0]  rd_data_reg;

    // Word walk datapath.
    logic [3:0]  word_idx_reg;
    logic [7:0]  v_hi_reg;
    logic [15:0] v_cur;
    logic        sq_sel_reg;
    logic        bad_reg;
    logic [pfp_pkg::MUL_A_W-1:0] prod_reg;
    logic [pfp_pkg::QUOT_W-1:0]  quot_reg;
    logic [pfp_pkg::REM_W-1:0]   rem_reg;
    logic [15:0] result_reg;

    logic [pfp_pkg::MUL_A_W-1:0] mul_a;
    logic [pfp_pkg::MUL_B_W-1:0] mul_b;
    logic [pfp_pkg::MUL_Y_W-1:0] mul_y;
    logic [pfp_pkg::MUL_B_W-1:0] divisor;
    logic [pfp_pkg::QUOT_W-1:0]  quot_fix;

    // Output register.
    logic        m_valid_reg;
    logic [55:0] m_data_reg;
    logic [1:0]  m_user_reg;
    logic        m_last_reg;

    logic        in_accept;
    logic        out_free;
    logic        checksum_ok;
    logic        word_last;
    logic        overload;
    logic [15:0] sum_next;

    // A byte is taken only while the sequencer is idle. A frame's last byte is also held
    // off while the previous result still waits, since it produces a result at once.
    assign s_tready  = (state_reg == S_IDLE) &&
                       ((pos_reg != pfp_pkg::POS_LAST) || !m_valid_reg);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    assign checksum_ok = (sum_reg == {cks_hi_reg, s_tdata});
    assign word_last   = bad_reg || (word_idx_reg == 4'(DATA_WORDS - 1));
    assign overload    = (held_pm25_reg >= threshold_reg);
    assign sum_next    = (pos_reg == pfp_pkg::POS_START_A) ? {8'd0, s_tdata}
                                                           : 16'(sum_reg + {8'd0, s_tdata});

    // Word i sits big-endian at bytes 4+2i and 5+2i.
    assign rd_addr = 5'(pfp_pkg::WORD_BASE + {word_idx_reg, 1'b0} +
                        {4'd0, (state_reg == S_RD_LO)});
    assign v_cur   = {v_hi_reg, rd_data_reg};

    // The shared multiplier: v*v or v*6 first, then the reciprocal of the divisor,
    // then quotient times divisor to get the remainder for the final correction.
    assign divisor = sq_sel_reg ? pfp_pkg::DIV_SQ : pfp_pkg::DIV_LIN;

    always_comb begin
        mul_a = prod_reg;
        mul_b = sq_sel_reg ? pfp_pkg::RECIP_SQ : pfp_pkg::RECIP_LIN;
        unique case (state_reg)
            S_CLASSIFY: begin
                mul_a = pfp_pkg::MUL_A_W'(v_cur);
                mul_b = (v_cur < pfp_pkg::SQ_LIMIT) ? pfp_pkg::MUL_B_W'(v_cur)
                                                    : pfp_pkg::GAIN_NUM;
            end
            S_MUL_REM: begin
                mul_a = pfp_pkg::MUL_A_W'(quot_reg);
                mul_b = divisor;
            end
            default: begin
                mul_a = prod_reg;
                mul_b = sq_sel_reg ? pfp_pkg::RECIP_SQ : pfp_pkg::RECIP_LIN;
            end
        endcase
    end

    assign mul_y = pfp_pkg::MUL_Y_W'(mul_a) * pfp_pkg::MUL_Y_W'(mul_b);

    // The reciprocal estimate is at most one low, so one compare settles the quotient.
    assign quot_fix = quot_reg +
                      pfp_pkg::QUOT_W'(pfp_pkg::MUL_B_W'(rem_reg) >= divisor);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_accept && (pos_reg == pfp_pkg::POS_LAST)) begin
                    state_next = checksum_ok ? S_RD_HI : S_LOAD_OUT;
                end
            end
            S_RD_HI:     state_next = S_RD_LO;
            S_RD_LO:     state_next = S_CLASSIFY;
            S_CLASSIFY:  state_next = (v_cur < pfp_pkg::LIN_LIMIT) ? S_LOAD_OUT : S_MUL_RECIP;
            S_MUL_RECIP: state_next = S_MUL_REM;
            S_MUL_REM:   state_next = S_FIX;
            S_FIX:       state_next = S_LOAD_OUT;
            S_LOAD_OUT: begin
                if (out_free) begin
                    state_next = word_last ? S_IDLE : S_RD_HI;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Frame memory: written on each accepted byte, read with a registered port.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            frame_mem[pos_reg] <= s_tdata;
        end
        rd_data_reg <= frame_mem[rd_addr];
    end

    // Configuration and control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= pfp_pkg::THRESHOLD_RESET;
            length_reg       <= pfp_pkg::LENGTH_RESET;
            state_reg        <= S_IDLE;
            pos_reg          <= 5'd0;
            held_pm25_reg    <= 16'd0;
            held_version_reg <= 8'd0;
            held_error_reg   <= 8'd0;
            word_idx_reg     <= 4'd0;
            bad_reg          <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_index)
                    pfp_pkg::REG_THRESHOLD: threshold_reg <= cfg_data;
                    pfp_pkg::REG_LENGTH:    length_reg    <= cfg_data[7:0];
                    default:                threshold_reg <= threshold_reg;
                endcase
            end

            if (in_accept) begin
                // A wrong header byte restarts the search without rechecking that byte.
                case (pos_reg)
                    pfp_pkg::POS_START_A:
                        pos_reg <= (s_tdata == pfp_pkg::START_A) ? 5'd1 : 5'd0;
                    pfp_pkg::POS_START_B:
                        pos_reg <= (s_tdata == pfp_pkg::START_B) ? 5'd2 : 5'd0;
                    pfp_pkg::POS_LENGTH:
                        pos_reg <= (s_tdata == length_reg) ? 5'd4 : 5'd0;
                    pfp_pkg::POS_LAST:
                        pos_reg <= 5'd0;
                    default:
                        pos_reg <= 5'(pos_reg + 5'd1);
                endcase

                if (pos_reg == pfp_pkg::POS_LAST) begin
                    word_idx_reg <= 4'd0;
                    bad_reg      <= !checksum_ok;
                    if (checksum_ok) begin
                        held_pm25_reg    <= {pm_hi_reg, pm_lo_reg};
                        held_version_reg <= version_reg;
                        held_error_reg   <= error_reg;
                    end
                end
            end

            if ((state_reg == S_LOAD_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
                if (!word_last) begin
                    word_idx_reg <= 4'(word_idx_reg + 4'd1);
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            if (pos_reg < pfp_pkg::POS_CKS_HI) begin
                sum_reg <= sum_next;
            end
            if (pos_reg == pfp_pkg::POS_PM_HI)   pm_hi_reg   <= s_tdata;
            if (pos_reg == pfp_pkg::POS_PM_LO)   pm_lo_reg   <= s_tdata;
            if (pos_reg == pfp_pkg::POS_VERSION) version_reg <= s_tdata;
            if (pos_reg == pfp_pkg::POS_ERROR)   error_reg   <= s_tdata;
            if (pos_reg == pfp_pkg::POS_CKS_HI)  cks_hi_reg  <= s_tdata;
            if ((pos_reg == pfp_pkg::POS_LAST) && !checksum_ok) begin
                result_reg <= 16'd0;
            end
        end

        case (state_reg)
            S_RD_LO: v_hi_reg <= rd_data_reg;
            S_CLASSIFY: begin
                result_reg <= v_cur;
                sq_sel_reg <= (v_cur < pfp_pkg::SQ_LIMIT);
                prod_reg   <= mul_y[pfp_pkg::MUL_A_W-1:0];
            end
            S_MUL_RECIP: quot_reg <= mul_y[pfp_pkg::RECIP_SHIFT +: pfp_pkg::QUOT_W];
            S_MUL_REM:   rem_reg  <= pfp_pkg::REM_W'(prod_reg - mul_y[pfp_pkg::MUL_A_W-1:0]);
            S_FIX:       result_reg <= quot_fix[16] ? 16'hFFFF : quot_fix[15:0];
            default:     v_hi_reg <= v_hi_reg;
        endcase

        if ((state_reg == S_LOAD_OUT) && out_free) begin
            m_data_reg <= {4'd0, held_error_reg, held_version_reg, held_pm25_reg,
                           result_reg, word_idx_reg};
            m_user_reg <= {overload, !bad_reg};
            m_last_reg <= word_last;
        end
    end

    // A rejected frame gives exactly one result, the last one, at word index zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tdata[3:0] == 4'd0)))
        else $error("rejected-frame result is not a lone last result");

    // A stalled output must keep the sequencer waiting in its load state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_LOAD_OUT) && m_valid_reg && !m_tready) |=> (state_reg == S_LOAD_OUT))
        else $error("sequencer moved on while the output was stalled");

    // No new byte is taken, and the word index stays in range, while the word walk is in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (!s_tready && (word_idx_reg < 4'(DATA_WORDS))))
        else $error("byte accepted or word index out of range during the word walk");

endmodule

### tb/tb_particle_sensor_frame_parser_top.sv
module tb_particle_sensor_frame_parser_top;

    localparam int NWORDS = pfp_pkg::DATA_WORDS_DEF;

    // One corrected word as it leaves the parser, with its sideband fields.
    typedef struct packed {
        logic [3:0]  index;
        logic [15:0] value;
        logic [15:0] pm25;
        logic [7:0]  version;
        logic [7:0]  err;
        logic        sum_ok;
        logic        overload;
        logic        last;
    } sensor_word_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;              // [3:0] word_index, [19:4] word_value, [35:20] pm25_level,
                                       // [43:36] version_byte, [51:44] error_byte, [55:52] zero
    logic [1:0]  m_tuser;              // [0] sum_ok, [1] overload
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data  = 16'h0000;

    particle_sensor_frame_parser_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the parser: position, frame bytes, held values and both registers.
    logic [4:0]  parse_pos;
    logic [7:0]  rx_frame [32];
    logic [15:0] held_pm25;
    logic [7:0]  held_version;
    logic [7:0]  held_error;
    logic [15:0] alarm_level;
    logic [7:0]  want_length;

    // Corrected words predicted but not yet seen on the result side, oldest first.
    sensor_word_t expected_words [$];

    // Words that the next frame will carry, filled by the test before sending.
    logic [15:0] frame_words [NWORDS];

    int error_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int hold_req_len   = 0;
    int hold_req_count = 0;
    int hold_ack_count = 0;

    sensor_word_t seen_word;
    sensor_word_t want_word;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the handshakes ever lock up.
    initial begin
        #1600000;
        $display("tb_particle_sensor_frame_parser_top: FAIL");
        $finish;
    end

    function automatic string show_word(input sensor_word_t w);
        return $sformatf("idx=%0d val=%0d pm25=%0d ver=%02h err=%02h ok=%0b ovl=%0b last=%0b",
                         w.index, w.value, w.pm25, w.version, w.err, w.sum_ok, w.overload,
                         w.last);
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    // Advance the shadow parser by one accepted byte and queue whatever words the
    // byte produces. Only the frame's final byte produces anything: twelve words
    // on a good checksum, one word flagged bad otherwise.
    task automatic parse_byte(input logic [7:0] b);
        logic [4:0]   p;
        logic [15:0]  sum;
        logic [15:0]  w;
        logic [31:0]  scaled;
        logic         ovl;
        int           i;
        sensor_word_t r;
        p = parse_pos;
        rx_frame[p] = b;
        if (p == pfp_pkg::POS_START_A) begin
            parse_pos = (b == pfp_pkg::START_A) ? 5'd1 : 5'd0;
        end else if (p == pfp_pkg::POS_START_B) begin
            // A wrong byte here is dropped; it is never retried as a start byte.
            parse_pos = (b == pfp_pkg::START_B) ? 5'd2 : 5'd0;
        end else if (p == pfp_pkg::POS_LENGTH) begin
            parse_pos = (b == want_length) ? 5'd4 : 5'd0;
        end else if (p != pfp_pkg::POS_LAST) begin
            parse_pos = p + 5'd1;
        end else begin
            parse_pos = 5'd0;
            sum = '0;
            for (i = 0; i < 30; i++) begin
                sum = sum + 16'(rx_frame[i]);
            end
            if (sum == {rx_frame[pfp_pkg::POS_CKS_HI], rx_frame[pfp_pkg::POS_LAST]}) begin
                // Held values are refreshed before the words are formed.
                held_pm25    = {rx_frame[pfp_pkg::POS_PM_HI], rx_frame[pfp_pkg::POS_PM_LO]};
                held_version = rx_frame[pfp_pkg::POS_VERSION];
                held_error   = rx_frame[pfp_pkg::POS_ERROR];
                ovl = (held_pm25 >= alarm_level);
                for (i = 0; i < NWORDS; i++) begin
                    w = {rx_frame[pfp_pkg::WORD_BASE + 2 * i],
                         rx_frame[pfp_pkg::WORD_BASE + 2 * i + 1]};
                    if (w < pfp_pkg::LIN_LIMIT) begin
                        r.value = w;
                    end else if (w < pfp_pkg::SQ_LIMIT) begin
                        scaled  = (32'(w) * 32'(w)) / 32'd500;
                        r.value = scaled[15:0];
                    end else begin
                        scaled  = (32'(w) * 32'd6) / 32'd5;
                        r.value = (scaled > 32'hFFFF) ? 16'hFFFF : scaled[15:0];
                    end
                    r.index    = 4'(i);
                    r.pm25     = held_pm25;
                    r.version  = held_version;
                    r.err      = held_error;
                    r.sum_ok   = 1'b1;
                    r.overload = ovl;
                    r.last     = (i == NWORDS - 1);
                    expected_words.push_back(r);
                end
            end else begin
                // Rejected frame: held values stay, overload still tracks the threshold.
                r.index    = '0;
                r.value    = '0;
                r.pm25     = held_pm25;
                r.version  = held_version;
                r.err      = held_error;
                r.sum_ok   = 1'b0;
                r.overload = (held_pm25 >= alarm_level);
                r.last     = 1'b1;
                expected_words.push_back(r);
            end
        end
    endtask

    // Result side: check each accepted word against the oldest prediction, then
    // decide whether to stall the next cycle. A long hold-off overrides the dice.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_word.index    = m_tdata[3:0];
            seen_word.value    = m_tdata[19:4];
            seen_word.pm25     = m_tdata[35:20];
            seen_word.version  = m_tdata[43:36];
            seen_word.err      = m_tdata[51:44];
            seen_word.sum_ok   = m_tuser[0];
            seen_word.overload = m_tuser[1];
            seen_word.last     = m_tlast;
            if (expected_words.size() == 0) begin
                note_error({"unexpected result: ", show_word(seen_word)});
            end else begin
                want_word = expected_words.pop_front();
                if (seen_word !== want_word) begin
                    note_error({"mismatch: expected ", show_word(want_word),
                                " got ", show_word(seen_word)});
                end
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (hold_cycles == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // The long receiver hold-off is loaded on request and counts itself down here,
    // one cycle per edge.
    always @(posedge aclk) begin
        if (hold_req_count != hold_ack_count) begin
            hold_cycles    <= hold_req_len;
            hold_ack_count <= hold_req_count;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // Offer one byte, with a random gap first when the sender is set to idle,
    // and hand it to the shadow parser once the block has taken it.
    task automatic send_byte(input logic [7:0] b);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        parse_byte(b);
    endtask

    // Stop sending and wait for every predicted word, then let the block settle
    // so a configuration write cannot land while it is still busy.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) begin
            @(posedge aclk);
        end
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == pfp_pkg::REG_THRESHOLD) begin
            alarm_level = data;
        end else begin
            want_length = data[7:0];
        end
        @(posedge aclk);
    endtask

    // Build a complete frame around frame_words with a correct header and checksum.
    // A corrupted frame gets one byte past the header flipped, which always breaks
    // the checksum without disturbing the header match.
    task automatic send_frame(input bit corrupt, input logic [7:0] version,
                              input logic [7:0] err_code);
        logic [7:0]  fb [32];
        logic [15:0] sum;
        int          i;
        int          k;
        fb[0] = pfp_pkg::START_A;
        fb[1] = pfp_pkg::START_B;
        fb[2] = 8'($urandom);
        fb[3] = want_length;
        for (i = 0; i < NWORDS; i++) begin
            fb[4 + 2 * i] = frame_words[i][15:8];
            fb[5 + 2 * i] = frame_words[i][7:0];
        end
        fb[pfp_pkg::POS_VERSION] = version;
        fb[pfp_pkg::POS_ERROR]   = err_code;
        sum = '0;
        for (i = 0; i < 30; i++) begin
            sum = sum + 16'(fb[i]);
        end
        fb[pfp_pkg::POS_CKS_HI] = sum[15:8];
        fb[pfp_pkg::POS_LAST]   = sum[7:0];
        if (corrupt) begin
            k = $urandom_range(4, 31);
            fb[k] = fb[k] ^ 8'($urandom_range(1, 255));
        end
        for (i = 0; i < 32; i++) begin
            send_byte(fb[i]);
        end
    endtask

    // Words drawn from every correction band, with the saturation edge well covered.
    task automatic fill_random_words();
        int i;
        for (i = 0; i < NWORDS; i++) begin
            case ($urandom_range(0, 4))
                0:       frame_words[i] = 16'($urandom_range(0, 499));
                1:       frame_words[i] = 16'($urandom_range(500, 599));
                2:       frame_words[i] = 16'($urandom_range(600, 54612));
                3:       frame_words[i] = 16'($urandom_range(54613, 65535));
                default: frame_words[i] = 16'($urandom);
            endcase
        end
    endtask

    // Random traffic: mostly well-formed frames, some with a broken checksum, with
    // line noise and aborted headers slipped in between. Noise never leaves the
    // parser mid-header, so the following frame still gets through.
    task automatic run_traffic(input int n_frames);
        logic [7:0] b;
        int         f;
        int         i;
        for (f = 0; f < n_frames; f++) begin
            case ($urandom_range(0, 3))
                1: begin
                    repeat ($urandom_range(1, 3)) begin
                        b = 8'($urandom);
                        send_byte((b == pfp_pkg::START_A) ? ~b : b);
                    end
                end
                2: begin
                    // A start byte followed by anything but the second start byte.
                    b = 8'($urandom);
                    send_byte(pfp_pkg::START_A);
                    send_byte((b == pfp_pkg::START_B) ? pfp_pkg::START_A : b);
                end
                3: begin
                    // A full header whose length byte is wrong.
                    send_byte(pfp_pkg::START_A);
                    send_byte(pfp_pkg::START_B);
                    send_byte(8'($urandom));
                    send_byte(want_length ^ 8'($urandom_range(1, 255)));
                end
                default: begin
                end
            endcase
            fill_random_words();
            send_frame($urandom_range(0, 4) == 0, 8'($urandom), 8'($urandom));
        end
    endtask

    // Header rejection: stray bytes at rest, a bad second start byte, a repeated
    // start byte that must not restart the frame, and wrong length bytes.
    // None of these may produce a result.
    task automatic test_header_rejects();
        wait_idle();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(pfp_pkg::START_B);
        send_byte(pfp_pkg::START_A);
        send_byte(8'h43);
        send_byte(pfp_pkg::START_A);
        send_byte(pfp_pkg::START_A);
        send_byte(pfp_pkg::START_B);
        send_byte(pfp_pkg::START_A);
        send_byte(pfp_pkg::START_B);
        send_byte(8'h00);
        send_byte(want_length - 8'd1);
        send_byte(pfp_pkg::START_A);
        send_byte(pfp_pkg::START_B);
        send_byte(8'hAA);
        send_byte(~want_length);
    endtask

    // One good frame with words on each side of every correction boundary and at
    // the saturation edge, PM2.5 sitting exactly on the reset threshold, then a
    // frame with a bad checksum that must report the held values.
    task automatic test_word_corrections();
        wait_idle();
        frame_words[0]  = 16'd0;
        frame_words[1]  = pfp_pkg::THRESHOLD_RESET;
        frame_words[2]  = 16'd499;
        frame_words[3]  = 16'd500;
        frame_words[4]  = 16'd599;
        frame_words[5]  = 16'd600;
        frame_words[6]  = 16'd54612;
        frame_words[7]  = 16'd54613;
        frame_words[8]  = 16'd54614;
        frame_words[9]  = 16'hFFFF;
        frame_words[10] = 16'd1;
        frame_words[11] = 16'h8001;
        send_frame(1'b0, 8'hFF, 8'h00);
        fill_random_words();
        send_frame(1'b1, 8'h00, 8'hFF);
    endtask

    // Threshold at zero raises overload on every frame end; no idling at all.
    task automatic test_no_idling();
        wait_idle();
        write_reg(pfp_pkg::REG_THRESHOLD, 16'h0000);
        write_reg(pfp_pkg::REG_LENGTH, 16'(pfp_pkg::LENGTH_RESET));
        send_idle_pct   = 0;
        recv_stall_pct <= 0;
        run_traffic(2);
    endtask

    // Threshold at its top and a zero length byte, with the sender leaving gaps.
    task automatic test_sender_gaps();
        wait_idle();
        write_reg(pfp_pkg::REG_THRESHOLD, 16'hFFFF);
        write_reg(pfp_pkg::REG_LENGTH, 16'h0000);
        send_idle_pct   = 46;
        recv_stall_pct <= 0;
        run_traffic(2);
    endtask

    // Largest length byte and a random threshold, with the receiver stalling.
    task automatic test_receiver_stalls();
        wait_idle();
        write_reg(pfp_pkg::REG_THRESHOLD, 16'($urandom));
        write_reg(pfp_pkg::REG_LENGTH, 16'h00FF);
        send_idle_pct   = 0;
        recv_stall_pct <= 46;
        run_traffic(2);
    endtask

    // Random settings for both registers, both sides idling.
    task automatic test_both_idle();
        wait_idle();
        write_reg(pfp_pkg::REG_THRESHOLD, 16'($urandom));
        write_reg(pfp_pkg::REG_LENGTH, 16'($urandom_range(0, 255)));
        send_idle_pct   = 36;
        recv_stall_pct <= 36;
        run_traffic(2);
    endtask

    // The receiver holds off for a long stretch while the sender keeps streaming,
    // so the first good frame end backs up into the input side.
    task automatic test_backpressure();
        wait_idle();
        write_reg(pfp_pkg::REG_THRESHOLD, pfp_pkg::THRESHOLD_RESET);
        write_reg(pfp_pkg::REG_LENGTH, 16'(pfp_pkg::LENGTH_RESET));
        send_idle_pct   = 0;
        recv_stall_pct <= 0;
        hold_req_len    = 400;
        hold_req_count  = hold_req_count + 1;
        fill_random_words();
        send_frame(1'b0, 8'($urandom), 8'($urandom));
        fill_random_words();
        send_frame(1'b0, 8'($urandom), 8'($urandom));
        run_traffic(1);
    endtask

    initial begin
        parse_pos    = '0;
        held_pm25    = '0;
        held_version = '0;
        held_error   = '0;
        alarm_level  = pfp_pkg::THRESHOLD_RESET;
        want_length  = pfp_pkg::LENGTH_RESET;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_header_rejects();
        test_word_corrections();
        test_no_idling();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_backpressure();

        // Drain, then give a good frame end time to show any stray extra word.
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) begin
            @(posedge aclk);
        end
        repeat (7 * NWORDS + 40) @(posedge aclk);
        if (expected_words.size() != 0) begin
            note_error("predicted words never arrived");
        end

        if (error_count == 0) begin
            $display("tb_particle_sensor_frame_parser_top: PASS");
        end else begin
            $display("tb_particle_sensor_frame_parser_top: FAIL");
        end
        $finish;
    end

endmodule
